@@ src/indexed_coordinate_list_defines.svh @@
// ----------------------------------------------------------------------------
// Indexed coordinate list assertion macros
// Property check shorthands for the coordinate list block.
// ----------------------------------------------------------------------------
`ifndef INDEXED_COORDINATE_LIST_DEFINES_SVH
`define INDEXED_COORDINATE_LIST_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ICL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("icl check failed");
`define ICL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("icl check failed");
`else
`define ICL_ASSERT_SAME(label, ante, cons)
`define ICL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/icl_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed coordinate list package
// Operation, status and cell mode codes; control struct for the cell row.
// ----------------------------------------------------------------------------
package icl_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_POS = 2'd2;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;
    localparam logic [1:0] CELL_READ = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [8:0]  slot;
        logic [31:0] data;
    } icl_ctrl_t;

endpackage

@@ src/indexed_coordinate_list.sv @@
// ----------------------------------------------------------------------------
// Indexed coordinate list
// Ordered list of (x, y) pairs with positional insert, delete, read and clear.
// ----------------------------------------------------------------------------
// One operation is taken per clock cycle; busy never rises. The result of an
// operation appears with done one cycle after the transfer of the command and
// stays for that one cycle only: the receiver must take it then. Each entry
// lives in its own cell of a row of MAX_ENTRIES cells, and an insert or delete
// shifts the whole tail of the row by one place in that single cycle, so the
// figure is set by the one-cycle update of the cell row.
module indexed_coordinate_list #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic [7:0]         position,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    output logic               done,
    output logic signed [15:0] read_x,
    output logic signed [15:0] read_y,
    output logic               hit,
    output logic [6:0]         list_length,
    output logic [1:0]         status
);

    `include "indexed_coordinate_list_defines.svh"

    localparam int         CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [8:0] MAX_CNT = 9'(MAX_ENTRIES);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    logic [31:0]        rd_word_reg;
    logic               hit_reg;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic               hit_next;
    logic [31:0]        rd_word;
    logic               accept;
    logic [8:0]         cnt9;
    logic [8:0]         pos9;
    logic [8:0]         cnt_out9;
    icl_pkg::icl_ctrl_t ctrl;

    logic [31:0] cell_q  [MAX_ENTRIES];
    logic [31:0] cell_rd [MAX_ENTRIES];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign cnt9   = 9'(count_reg);
    assign pos9   = {1'b0, position};

    always_comb
    begin
        ctrl.mode   = icl_pkg::CELL_HOLD;
        ctrl.slot   = pos9 - 9'd1;
        ctrl.data   = {coord_x, coord_y};
        count_next  = count_reg;
        status_next = icl_pkg::ST_OK;
        hit_next    = 1'b0;
        if (accept)
        begin
            case (operation)
                icl_pkg::OP_INSERT:
                begin
                    if (cnt9 >= MAX_CNT)
                        status_next = icl_pkg::ST_FULL;
                    else
                    begin
                        ctrl.mode  = icl_pkg::CELL_INS;
                        count_next = count_reg + CNT_W'(1);
                        if (pos9 <= 9'd1)
                            ctrl.slot = 9'd0;
                        else if (pos9 > cnt9)
                            ctrl.slot = cnt9;
                    end
                end
                icl_pkg::OP_DELETE:
                begin
                    if (pos9 == 9'd0 || pos9 > cnt9)
                        status_next = icl_pkg::ST_BAD_POS;
                    else
                    begin
                        ctrl.mode  = icl_pkg::CELL_DEL;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                icl_pkg::OP_READ:
                begin
                    if (pos9 != 9'd0 && pos9 <= cnt9)
                    begin
                        ctrl.mode = icl_pkg::CELL_READ;
                        hit_next  = 1'b1;
                    end
                end
                default:
                begin
                    count_next = '0;
                end
            endcase
        end
    end

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [31:0] prev_d;
        logic [31:0] next_d;
        if (i == 0)
        begin : g_head
            assign prev_d = cell_q[i];
        end
        else
        begin : g_body
            assign prev_d = cell_q[i-1];
        end
        if (i == MAX_ENTRIES - 1)
        begin : g_tail
            assign next_d = cell_q[i];
        end
        else
        begin : g_mid
            assign next_d = cell_q[i+1];
        end
        icl_cell #(
            .INDEX (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_q[i]),
            .rd_data   (cell_rd[i])
        );
    end

    always_comb
    begin
        rd_word = 32'd0;
        for (int k = 0; k < MAX_ENTRIES; k++)
            rd_word = rd_word | cell_rd[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_word_reg <= rd_word;
        hit_reg     <= hit_next;
        status_reg  <= status_next;
    end

    assign cnt_out9    = 9'(count_reg);
    assign done        = done_reg;
    assign read_x      = rd_word_reg[31:16];
    assign read_y      = rd_word_reg[15:0];
    assign hit         = done_reg && hit_reg;
    assign list_length = cnt_out9[6:0];
    assign status      = status_reg;

    `ICL_ASSERT_SAME(a_count_bound, 1'b1, cnt_out9 <= MAX_CNT)
    `ICL_ASSERT_NEXT(a_done_follows, accept, done)
    `ICL_ASSERT_SAME(a_full_count, done && status == icl_pkg::ST_FULL, cnt_out9 == MAX_CNT)
    `ICL_ASSERT_SAME(a_hit_ok, hit, done && status == icl_pkg::ST_OK)

endmodule

@@ src/icl_cell.sv @@
// ----------------------------------------------------------------------------
// Coordinate list cell
// Holds one entry; shifts from a neighbor on insert or delete, drives read bus.
// ----------------------------------------------------------------------------
module icl_cell #(
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  icl_pkg::icl_ctrl_t ctrl,
    input  logic [31:0]       prev_data,
    input  logic [31:0]       next_data,
    output logic [31:0]       data,
    output logic [31:0]       rd_data
);

    localparam logic [8:0] MY_IDX = 9'(INDEX);

    logic [31:0] data_reg;
    logic [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.mode)
            icl_pkg::CELL_INS:
            begin
                if (ctrl.slot == MY_IDX)
                    data_next = ctrl.data;
                else if (MY_IDX > ctrl.slot)
                    data_next = prev_data;
            end
            icl_pkg::CELL_DEL:
            begin
                if (MY_IDX >= ctrl.slot)
                    data_next = next_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (ctrl.mode == icl_pkg::CELL_READ && ctrl.slot == MY_IDX)
                     ? data_reg : 32'd0;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed coordinate list testbench
// Drives insert, delete, read and clear commands into the coordinate list.
// A short stimulus table with some results typed in comes first. Random runs
// follow that fill the list, drain it and mix operations, with idle gaps. The
// other results are checked against a list model held in the bench.
// ----------------------------------------------------------------------------
module tb;

    localparam int CAP         = 64;
    localparam int RAND_ITEMS  = 1900;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic               hit;
        logic [6:0]         len;
        logic [1:0]         st;
    } list_result_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         pos;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               fixed;
        list_result_t       want;
    } cmd_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         operation;
    logic [7:0]         position;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic               done;
    logic signed [15:0] read_x;
    logic signed [15:0] read_y;
    logic               hit;
    logic [6:0]         list_length;
    logic [1:0]         status;

    // bench copy of the list: x in the high half, y in the low half
    logic [31:0]        list_xy [CAP];
    int                 list_cnt;

    list_result_t       pending_results [$];
    logic               cur_fixed;
    list_result_t       cur_want;
    int                 gap_pct;
    int                 errors;
    int                 cycles;
    int                 n_ins, n_del, n_rd, n_clr, n_full, n_bad, n_hit, peak_len;

    indexed_coordinate_list #(
        .MAX_ENTRIES(CAP)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .position   (position),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .done       (done),
        .read_x     (read_x),
        .read_y     (read_y),
        .hit        (hit),
        .list_length(list_length),
        .status     (status)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic list_result_t apply_list_op(input logic [1:0] op,
                                                   input logic [7:0] pos,
                                                   input logic signed [15:0] x,
                                                   input logic signed [15:0] y);
        list_result_t r;
        int           slot;
        int           i;
        r = '0;
        r.st = icl_pkg::ST_OK;
        case (op)
            icl_pkg::OP_INSERT:
            begin
                n_ins++;
                if (list_cnt >= CAP)
                begin
                    r.st = icl_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    if (pos <= 1)
                        slot = 0;
                    else if (int'(pos) > list_cnt)
                        slot = list_cnt;
                    else
                        slot = int'(pos) - 1;
                    for (i = list_cnt; i > slot; i--)
                        list_xy[i] = list_xy[i - 1];
                    list_xy[slot] = {x, y};
                    list_cnt++;
                end
            end
            icl_pkg::OP_DELETE:
            begin
                n_del++;
                if (pos < 1 || int'(pos) > list_cnt)
                begin
                    r.st = icl_pkg::ST_BAD_POS;
                    n_bad++;
                end
                else
                begin
                    for (i = int'(pos) - 1; i + 1 < list_cnt; i++)
                        list_xy[i] = list_xy[i + 1];
                    list_cnt--;
                end
            end
            icl_pkg::OP_READ:
            begin
                n_rd++;
                if (pos >= 1 && int'(pos) <= list_cnt)
                begin
                    r.rx  = list_xy[pos - 1][31:16];
                    r.ry  = list_xy[pos - 1][15:0];
                    r.hit = 1'b1;
                    n_hit++;
                end
            end
            default:
            begin
                n_clr++;
                list_cnt = 0;
            end
        endcase
        if (list_cnt > peak_len)
            peak_len = list_cnt;
        r.len = list_cnt[6:0];
        return r;
    endfunction

    task automatic check_result(input list_result_t want);
        if (read_x !== want.rx)
        begin
            $error("read_x: expected %0d, got %0d", want.rx, read_x);
            errors++;
        end
        if (read_y !== want.ry)
        begin
            $error("read_y: expected %0d, got %0d", want.ry, read_y);
            errors++;
        end
        if (hit !== want.hit)
        begin
            $error("hit: expected %0d, got %0d", want.hit, hit);
            errors++;
        end
        if (list_length !== want.len)
        begin
            $error("list_length: expected %0d, got %0d", want.len, list_length);
            errors++;
        end
        if (status !== want.st)
        begin
            $error("status: expected %0d, got %0d", want.st, status);
            errors++;
        end
    endtask

    // transfers are logged before results are checked, so any latency works
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (cur_fixed)
                begin
                    void'(apply_list_op(operation, position, coord_x, coord_y));
                    pending_results.push_back(cur_want);
                end
                else
                    pending_results.push_back(apply_list_op(operation, position,
                                                            coord_x, coord_y));
            end
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    errors++;
                end
                else
                    check_result(pending_results.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_cmd(input logic [1:0] op, input logic [7:0] pos,
                            input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic fixed, input list_result_t want);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start     = 1'b0;
            operation = 2'($urandom);
            position  = 8'($urandom);
            @(negedge clk);
        end
        start     = 1'b1;
        operation = op;
        position  = pos;
        coord_x   = x;
        coord_y   = y;
        cur_fixed = fixed;
        cur_want  = want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    cmd_row_t dir_rows [25] = '{
        '{icl_pkg::OP_READ,   8'd1,   16'sd0,     16'sd0,     1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd0, icl_pkg::ST_OK}},
        '{icl_pkg::OP_DELETE, 8'd1,   16'sd0,     16'sd0,     1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd0, icl_pkg::ST_BAD_POS}},
        '{icl_pkg::OP_INSERT, 8'd7,   16'sh7FFF,  16'sh8000,  1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd1, icl_pkg::ST_OK}},
        '{icl_pkg::OP_READ,   8'd1,   16'sd0,     16'sd0,     1'b1,
          '{16'sh7FFF, 16'sh8000, 1'b1, 7'd1, icl_pkg::ST_OK}},
        '{icl_pkg::OP_INSERT, 8'd0,   16'sh8000,  16'sh7FFF,  1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd2, icl_pkg::ST_OK}},
        '{icl_pkg::OP_INSERT, 8'd255, 16'sh0001,  16'shFFFF,  1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd3, icl_pkg::ST_OK}},
        '{icl_pkg::OP_INSERT, 8'd1,   16'sh1234,  16'sh5678,  1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd4, icl_pkg::ST_OK}},
        '{icl_pkg::OP_INSERT, 8'd3,   16'shFFFE,  16'sh0002,  1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd5, icl_pkg::ST_OK}},
        '{icl_pkg::OP_READ,   8'd1,   16'sd0,     16'sd0,     1'b0, '0},
        '{icl_pkg::OP_READ,   8'd2,   16'sd0,     16'sd0,     1'b0, '0},
        '{icl_pkg::OP_READ,   8'd3,   16'sd0,     16'sd0,     1'b0, '0},
        '{icl_pkg::OP_READ,   8'd4,   16'sd0,     16'sd0,     1'b0, '0},
        '{icl_pkg::OP_READ,   8'd5,   16'sd0,     16'sd0,     1'b0, '0},
        '{icl_pkg::OP_READ,   8'd0,   16'shFFFF,  16'shFFFF,  1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd5, icl_pkg::ST_OK}},
        '{icl_pkg::OP_READ,   8'd255, 16'sd0,     16'sd0,     1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd5, icl_pkg::ST_OK}},
        '{icl_pkg::OP_READ,   8'd6,   16'sd0,     16'sd0,     1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd5, icl_pkg::ST_OK}},
        '{icl_pkg::OP_DELETE, 8'd0,   16'sd0,     16'sd0,     1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd5, icl_pkg::ST_BAD_POS}},
        '{icl_pkg::OP_DELETE, 8'd6,   16'sd0,     16'sd0,     1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd5, icl_pkg::ST_BAD_POS}},
        '{icl_pkg::OP_DELETE, 8'd3,   16'sd0,     16'sd0,     1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd4, icl_pkg::ST_OK}},
        '{icl_pkg::OP_DELETE, 8'd4,   16'sd0,     16'sd0,     1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd3, icl_pkg::ST_OK}},
        '{icl_pkg::OP_READ,   8'd2,   16'sd0,     16'sd0,     1'b0, '0},
        '{icl_pkg::OP_CLEAR,  8'd255, 16'shFFFF,  16'shFFFF,  1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd0, icl_pkg::ST_OK}},
        '{icl_pkg::OP_READ,   8'd1,   16'sd0,     16'sd0,     1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd0, icl_pkg::ST_OK}},
        '{icl_pkg::OP_INSERT, 8'd2,   16'shFFFF,  16'shFFFF,  1'b1,
          '{16'sd0, 16'sd0, 1'b0, 7'd1, icl_pkg::ST_OK}},
        '{icl_pkg::OP_READ,   8'd1,   16'sd0,     16'sd0,     1'b1,
          '{16'shFFFF, 16'shFFFF, 1'b1, 7'd1, icl_pkg::ST_OK}}
    };

    initial
    begin
        int          k;
        int          n;
        int          seg_len;
        int          mode;
        int          ins_pct, del_pct, clr_pct;
        int          r;
        logic [1:0]  op;
        logic [7:0]  pos;

        rst_n     = 1'b0;
        start     = 1'b0;
        operation = icl_pkg::OP_READ;
        position  = '0;
        coord_x   = '0;
        coord_y   = '0;
        cur_fixed = 1'b0;
        cur_want  = '0;
        gap_pct   = 9;
        errors    = 0;
        cycles    = 0;
        list_cnt  = 0;
        n_ins = 0; n_del = 0; n_rd = 0; n_clr = 0;
        n_full = 0; n_bad = 0; n_hit = 0; peak_len = 0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (k = 0; k < 25; k++)
            send_cmd(dir_rows[k].op, dir_rows[k].pos, dir_rows[k].x, dir_rows[k].y,
                     dir_rows[k].fixed, dir_rows[k].want);

        // the first segment fills; later ones pick filling, draining or mixed traffic at random
        n    = 0;
        mode = 0;
        while (n < RAND_ITEMS)
        begin
            seg_len = (n == 0) ? 150 : $urandom_range(40, 160);
            case (mode)
                0:       begin ins_pct = 75; del_pct = 10; clr_pct = 0; end
                1:       begin ins_pct = 15; del_pct = 60; clr_pct = 0; end
                2:       begin ins_pct = 35; del_pct = 30; clr_pct = 3; end
                default: begin ins_pct = 20; del_pct = 15; clr_pct = 1; end
            endcase
            for (k = 0; k < seg_len && n < RAND_ITEMS; k++)
            begin
                gap_pct = (n >= 700 && n < 1000) ? 0 : 9;
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    op = icl_pkg::OP_INSERT;
                else if (r < ins_pct + del_pct)
                    op = icl_pkg::OP_DELETE;
                else if (r < ins_pct + del_pct + clr_pct)
                    op = icl_pkg::OP_CLEAR;
                else
                    op = icl_pkg::OP_READ;
                r = $urandom_range(0, 99);
                if (r < 70)
                    pos = (list_cnt == 0) ? 8'd1 : 8'($urandom_range(1, list_cnt));
                else if (r < 80)
                    pos = 8'(list_cnt + 1);
                else if (r < 85)
                    pos = 8'd0;
                else
                    pos = 8'($urandom_range(0, 255));
                send_cmd(op, pos, rand_coord(), rand_coord(), 1'b0, '0);
                n++;
            end
            mode = $urandom_range(0, 3);
        end

        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d inserts (%0d refused full), %0d deletes (%0d bad position)",
                 n_ins, n_full, n_del, n_bad);
        $display("covered %0d reads (%0d hits), %0d clears, peak length %0d of %0d",
                 n_rd, n_hit, n_clr, peak_len, CAP);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
